// File: sv/tbsg_pkg.sv
// Package for the trapezoid step generator: constants, shared types and helpers.
// Used by the divider, register file and top-level files; depends on nothing.
`default_nettype none
package tbsg_pkg;

    localparam int DEF_STEP_COUNT_BITS = 24;
    localparam int DEF_NUM_AXES        = 3;
    localparam int MAX_AXES            = 3;

    localparam logic [31:0] ONE_Q16         = 32'd65536;
    localparam logic [31:0] SPEED_FLOOR_Q16 = 32'd6553;
    localparam logic [63:0] MIN_RATE_Q16    = 64'd60 * 64'd65536;
    localparam logic [15:0] PERIOD_MIN      = 16'd100;
    localparam logic [15:0] PERIOD_MAX      = 16'd65535;
    localparam logic [31:0] CLOCK_HZ_RESET  = 32'd16000000;

    localparam logic [1:0] REG_STEP_INV = 2'd0;
    localparam logic [1:0] REG_DIR_INV  = 2'd1;
    localparam logic [1:0] REG_CLOCK_HZ = 2'd2;

    localparam logic [1:0] ST_STEPPED   = 2'd0;
    localparam logic [1:0] ST_IDLE_TICK = 2'd1;
    localparam logic [1:0] ST_LOADED    = 2'd2;
    localparam logic [1:0] ST_REJECTED  = 2'd3;

    typedef struct packed {
        logic [2:0]  step_inv;
        logic [2:0]  dir_inv;
        logic [31:0] clock_hz;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/tbsg_if.sv
// Request and result channel interfaces of the step generator.
// Depends on nothing.
`default_nettype none
interface tbsg_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [23:0] steps_x;
    logic [23:0] steps_y;
    logic [23:0] steps_z;
    logic [23:0] event_total;
    logic [2:0]  dir_in;
    logic [31:0] length_mm;
    logic [31:0] accel;
    logic [31:0] nominal_speed_in;
    logic [31:0] entry_speed_in;
    logic [31:0] exit_speed_in;
    modport source (output valid, req_type, steps_x, steps_y, steps_z, event_total, dir_in,
                    length_mm, accel, nominal_speed_in, entry_speed_in, exit_speed_in,
                    input ready);
    modport sink (input valid, req_type, steps_x, steps_y, steps_z, event_total, dir_in,
                  length_mm, accel, nominal_speed_in, entry_speed_in, exit_speed_in,
                  output ready);
endinterface

interface tbsg_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         step_out;
    logic [2:0]         dir_out;
    logic [15:0]        timer_period;
    logic               busy_res;
    logic [1:0]         status;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source (output valid, step_out, dir_out, timer_period, busy_res, status,
                    pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, step_out, dir_out, timer_period, busy_res, status,
                  pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

// File: sv/tbsg_div.sv
// Shared restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Depends on tbsg_pkg for the request and response structs.
`default_nettype none
module tbsg_div import tbsg_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [63:0] r_num, n_num;
    logic [63:0] r_den;
    logic [63:0] r_rem, n_rem;
    logic [6:0]  r_cnt;
    logic        r_done;
    logic [64:0] rem_sh;
    logic        qbit;

    // The quotient bits shift into the dividend register as its bits are used up.
    always_comb begin
        rem_sh = {r_rem, r_num[63]};
        qbit   = (rem_sh >= {1'b0, r_den});
        n_rem  = qbit ? 64'(rem_sh - {1'b0, r_den}) : rem_sh[63:0];
        n_num  = {r_num[62:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= 7'd64;
            end else if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_cnt != 7'd0) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
endmodule
`default_nettype wire

// File: sv/tbsg_cfg.sv
// APB-style register file: invert masks and timer clock frequency.
// Depends on tbsg_pkg for the register indexes and the t_cfg struct.
`default_nettype none
module tbsg_cfg import tbsg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);
    t_cfg r_cfg;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_inv <= '0;
            r_cfg.dir_inv  <= '0;
            r_cfg.clock_hz <= CLOCK_HZ_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_STEP_INV: r_cfg.step_inv <= pwdata[2:0];
                REG_DIR_INV:  r_cfg.dir_inv  <= pwdata[2:0];
                REG_CLOCK_HZ: r_cfg.clock_hz <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STEP_INV: prdata = {29'd0, r_cfg.step_inv};
            REG_DIR_INV:  prdata = {29'd0, r_cfg.dir_inv};
            REG_CLOCK_HZ: prdata = r_cfg.clock_hz;
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// File: sv/trapezoid_bresenham_step_generator.sv
// Three-axis Bresenham step generator with a trapezoidal speed profile. One request
// is taken at a time; ready is high only while the sequencer is idle. An idle tick
// skips the divider and goes straight to the output state. Each division on the
// shared 64-bit divider has a start state, then its 64 quotient bits, then a wait
// state in which its result is taken. A load takes three divisions and a busy load
// takes two. A step tick takes two to four divisions plus the multiplies for the
// distance, stop-distance and speed-change terms. A finished result waits in the
// output register.
`default_nettype none
module trapezoid_bresenham_step_generator import tbsg_pkg::*; #(
    parameter int STEP_COUNT_BITS = DEF_STEP_COUNT_BITS,
    parameter int NUM_AXES        = DEF_NUM_AXES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tbsg_in_if.sink          i_req,
    tbsg_out_if.source       o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int W = STEP_COUNT_BITS;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_MPE    = 5'd1;
    localparam logic [4:0] S_MWAIT  = 5'd2;
    localparam logic [4:0] S_MULD   = 5'd3;
    localparam logic [4:0] S_DIST   = 5'd4;
    localparam logic [4:0] S_MV2    = 5'd5;
    localparam logic [4:0] S_ME2    = 5'd6;
    localparam logic [4:0] S_SDIV   = 5'd7;
    localparam logic [4:0] S_SWAIT  = 5'd8;
    localparam logic [4:0] S_DECIDE = 5'd9;
    localparam logic [4:0] S_MDL    = 5'd10;
    localparam logic [4:0] S_DDIV   = 5'd11;
    localparam logic [4:0] S_DWAIT  = 5'd12;
    localparam logic [4:0] S_PER0   = 5'd13;
    localparam logic [4:0] S_PWAIT  = 5'd14;
    localparam logic [4:0] S_PER1   = 5'd15;
    localparam logic [4:0] S_PWAIT2 = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    tbsg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tbsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    logic [4:0]   r_state;
    logic [W:0]   r_accum [MAX_AXES];
    logic [W-1:0] r_steps [MAX_AXES];
    logic [31:0]  r_pos   [MAX_AXES];
    logic [W-1:0] r_eib, r_eleft;
    logic [2:0]   r_dir;
    logic         r_running;
    logic [31:0]  r_len, r_acc, r_cruise, r_end, r_speed, r_mpe, r_dist;
    logic [63:0]  r_prod, r_tmp;
    logic [31:0]  r_stop;
    logic         r_dec;
    logic [1:0]   r_status;
    logic [2:0]   r_step;
    logic [15:0]  r_period;

    logic         r_out_valid;
    logic [2:0]   r_o_step, r_o_dir;
    logic [15:0]  r_o_period;
    logic         r_o_busy;
    logic [1:0]   r_o_status;
    logic [31:0]  r_o_pos [MAX_AXES];

    logic [31:0]  mul_a, mul_b;
    logic [W-1:0] done_cnt;
    logic [31:0]  speed_fl;
    logic [31:0]  left;
    logic [31:0]  delta;
    logic [32:0]  speed_sum;
    logic [31:0]  ev_ext;
    logic [W-1:0] ev_load;
    logic [31:0]  sx_ext, sy_ext, sz_ext;

    assign done_cnt  = r_eib - r_eleft;
    assign speed_fl  = (r_speed < SPEED_FLOOR_Q16) ? SPEED_FLOOR_Q16 : r_speed;
    assign left      = (r_len > r_dist) ? (r_len - r_dist) : 32'd0;
    assign delta     = sat32(div_rsp.quot);
    assign speed_sum = {1'b0, r_speed} + {1'b0, delta};
    assign ev_ext    = 32'(i_req.event_total);
    assign ev_load   = (ev_ext[W-1:0] == '0) ? W'(1) : ev_ext[W-1:0];
    assign sx_ext    = 32'(i_req.steps_x);
    assign sy_ext    = 32'(i_req.steps_y);
    assign sz_ext    = 32'(i_req.steps_z);

    // The one multiplier, shared by the distance, stop-distance and speed-change terms.
    always_comb begin
        case (r_state)
            S_MULD:  begin mul_a = 32'(done_cnt); mul_b = r_mpe;   end
            S_MV2:   begin mul_a = r_speed;       mul_b = r_speed; end
            S_ME2:   begin mul_a = r_end;         mul_b = r_end;   end
            S_MDL:   begin mul_a = r_acc;         mul_b = r_mpe;   end
            default: begin mul_a = '0;            mul_b = '0;      end
        endcase
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (r_state)
            S_MPE: begin
                div_req.start    = 1'b1;
                div_req.dividend = {24'd0, r_len, 8'd0};
                div_req.divisor  = 64'(r_eib);
            end
            S_SDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_tmp - r_prod;
                div_req.divisor  = {31'd0, r_acc, 1'b0};
            end
            S_DDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod;
                div_req.divisor  = {24'd0, r_speed, 8'd0};
            end
            S_PER0: begin
                div_req.start    = 1'b1;
                div_req.dividend = {8'd0, speed_fl, 24'd0};
                div_req.divisor  = {32'd0, r_mpe};
            end
            S_PER1: begin
                div_req.start    = 1'b1;
                div_req.dividend = {16'd0, cfg.clock_hz, 16'd0};
                div_req.divisor  = r_tmp;
            end
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            for (int a = 0; a < MAX_AXES; a++) begin
                r_accum[a] <= '0;
                r_steps[a] <= '0;
                r_pos[a]   <= '0;
            end
            r_eib     <= '0;
            r_eleft   <= '0;
            r_dir     <= '0;
            r_running <= 1'b0;
            r_len     <= '0;
            r_acc     <= '0;
            r_cruise  <= '0;
            r_end     <= '0;
            r_speed   <= '0;
            r_mpe     <= '0;
            r_dist    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        if (i_req.req_type) begin
                            r_step <= '0;
                            if (r_running) begin
                                r_status <= ST_REJECTED;
                                r_state  <= S_PER0;
                            end else begin
                                r_steps[0] <= sx_ext[W-1:0];
                                r_steps[1] <= sy_ext[W-1:0];
                                r_steps[2] <= sz_ext[W-1:0];
                                for (int a = 0; a < MAX_AXES; a++) begin
                                    r_accum[a] <= {1'b0, ev_load >> 1};
                                end
                                r_eib     <= ev_load;
                                r_eleft   <= ev_load;
                                r_dir     <= i_req.dir_in;
                                r_len     <= i_req.length_mm;
                                r_acc     <= i_req.accel;
                                r_cruise  <= i_req.nominal_speed_in;
                                r_end     <= i_req.exit_speed_in;
                                r_speed   <= (i_req.entry_speed_in < ONE_Q16) ?
                                             ONE_Q16 : i_req.entry_speed_in;
                                r_dist    <= '0;
                                r_running <= 1'b1;
                                r_status  <= ST_LOADED;
                                r_state   <= S_MPE;
                            end
                        end else if (!r_running) begin
                            r_step   <= '0;
                            r_status <= ST_IDLE_TICK;
                            r_period <= PERIOD_MAX;
                            r_state  <= S_FIN;
                        end else begin
                            // One Bresenham event: every axis below NUM_AXES works in parallel; the others do not step.
                            for (int a = 0; a < MAX_AXES; a++) begin
                                if (a < NUM_AXES) begin
                                    logic [W:0] acc_n;
                                    acc_n = r_accum[a] + {1'b0, r_steps[a]};
                                    if (acc_n > {1'b0, r_eib}) begin
                                        r_step[a]  <= 1'b1;
                                        r_accum[a] <= acc_n - {1'b0, r_eib};
                                        r_pos[a]   <= r_dir[a] ? r_pos[a] - 32'd1 :
                                                                 r_pos[a] + 32'd1;
                                    end else begin
                                        r_step[a]  <= 1'b0;
                                        r_accum[a] <= acc_n;
                                    end
                                end else begin
                                    r_step[a] <= 1'b0;
                                end
                            end
                            if (r_eleft != '0) begin
                                r_eleft <= r_eleft - W'(1);
                            end
                            r_status <= ST_STEPPED;
                            r_state  <= S_MULD;
                        end
                    end
                end
                S_MPE:   r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (div_rsp.done) begin
                        r_mpe   <= sat32(div_rsp.quot);
                        r_state <= S_PER0;
                    end
                end
                S_MULD: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    r_dist <= sat32({8'd0, r_prod[63:8]});
                    if (r_speed > r_end) begin
                        r_state <= S_MV2;
                    end else begin
                        r_stop  <= '0;
                        r_state <= S_DECIDE;
                    end
                end
                S_MV2: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_ME2;
                end
                S_ME2: begin
                    r_tmp   <= r_prod;
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_SDIV;
                end
                S_SDIV:  r_state <= S_SWAIT;
                S_SWAIT: begin
                    if (div_rsp.done) begin
                        r_stop  <= sat32(div_rsp.quot);
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (left <= r_stop) begin
                        r_dec   <= 1'b1;
                        r_state <= (r_speed > ONE_Q16) ? S_MDL : S_PER0;
                    end else begin
                        r_dec   <= 1'b0;
                        r_state <= (r_speed < r_cruise) ? S_MDL : S_PER0;
                    end
                end
                S_MDL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_DDIV;
                end
                S_DDIV:  r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        if (r_dec) begin
                            r_speed <= (delta >= r_speed - ONE_Q16) ? ONE_Q16 :
                                       r_speed - delta;
                        end else begin
                            r_speed <= (speed_sum > {1'b0, r_cruise}) ? r_cruise :
                                       speed_sum[31:0];
                        end
                        r_state <= S_PER0;
                    end
                end
                S_PER0:  r_state <= S_PWAIT;
                S_PWAIT: begin
                    if (div_rsp.done) begin
                        r_tmp   <= (div_rsp.quot < MIN_RATE_Q16) ? MIN_RATE_Q16 :
                                   div_rsp.quot;
                        r_state <= S_PER1;
                    end
                end
                S_PER1:   r_state <= S_PWAIT2;
                S_PWAIT2: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quot > 64'(PERIOD_MAX)) begin
                            r_period <= PERIOD_MAX;
                        end else if (div_rsp.quot < 64'(PERIOD_MIN)) begin
                            r_period <= PERIOD_MIN;
                        end else begin
                            r_period <= div_rsp.quot[15:0];
                        end
                        if (r_status == ST_STEPPED && r_eleft == '0) begin
                            r_running <= 1'b0;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_out_valid || o_res.ready)) begin
            r_o_step   <= r_step ^ cfg.step_inv;
            r_o_dir    <= r_dir ^ cfg.dir_inv;
            r_o_period <= r_period;
            r_o_busy   <= r_running;
            r_o_status <= r_status;
            for (int a = 0; a < MAX_AXES; a++) begin
                r_o_pos[a] <= r_pos[a];
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.step_out     = r_o_step;
    assign o_res.dir_out      = r_o_dir;
    assign o_res.timer_period = r_o_period;
    assign o_res.busy_res     = r_o_busy;
    assign o_res.status       = r_o_status;
    assign o_res.pos_x        = $signed(r_o_pos[0]);
    assign o_res.pos_y        = $signed(r_o_pos[1]);
    assign o_res.pos_z        = $signed(r_o_pos[2]);
endmodule
`default_nettype wire
